### hdl/cgi_pkg.sv
// Shared types and constants for the color gradient interpolator.
package cgi_pkg;

  localparam int TIME_W    = 16;  // Q1.15 age and stop time
  localparam int CHAN_W    = 8;   // one color channel
  localparam int STOP_W    = 48;  // packed stop register
  localparam int CNT_W     = 3;   // stop_count register
  localparam int CFG_IDX_W = 3;   // config register index
  localparam int T_W       = 15;  // blend fraction bits (t < 1.0 inside a segment)
  localparam int MIX_W     = 24;  // channel * Q1.15 weight, summed

  // Divider pipeline: quotient bits resolved per stage and number of stages
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = T_W / DIV_STEP;

  // Select stage, setup stage, divider stages, blend/output stage
  localparam int NUM_STAGES = 2 + DIV_STAGES + 1;

  localparam logic signed [TIME_W:0] MIN_DIFF = 17'sd4;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = 3'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

endpackage

### hdl/color_gradient_interpolator.sv
// Top level: pipelined piecewise-linear RGBA gradient lookup.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, age_i             | beat in
//  out      | out_valid_o, out_ready_i, red_o, green_o, | beat out
//           |   blue_o, alpha_o                         |
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write only
//
// One beat per cycle while out_ready_i is high; the stages are segment select, setup,
// five divider stages of three quotient bits each, and the blend/output register.
// The Q0.15 fraction divider sets the depth.
// Each stage holds a valid bit and advances when it is empty or the stage
// after it advances, so bubbles collapse and a stall drops nothing.
// Reset clears valid bits, stop_count (to 1) and the stop registers.
module color_gradient_interpolator
  import cgi_pkg::*;
#(
  parameter int MAX_STOPS = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [STOP_W-1:0]    cfg_wdata_i,
  // age input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_W-1:0]    age_i,
  // color output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAN_W-1:0]    red_o,
  output logic [CHAN_W-1:0]    green_o,
  output logic [CHAN_W-1:0]    blue_o,
  output logic [CHAN_W-1:0]    alpha_o
);

  localparam int SEL_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_q;
  logic [STOP_W-1:0] stop_q [MAX_STOPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(1);
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STOP_COUNT) begin
        cnt_q <= cfg_wdata_i[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_idx_i == REG_STOP_BASE + CFG_IDX_W'(k)) begin
          stop_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: stage k advances if empty or stage k+1 advances
  // ---------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: segment select. All stop compares in parallel, first stop
  // whose time exceeds the age ends the segment.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_m1;
  logic [SEL_W-1:0]  last_idx;
  logic [SEL_W-1:0]  seg_idx;
  logic [SEL_W-1:0]  nxt_idx;
  logic              seg_last;
  logic [MAX_STOPS-1:0] past;

  always_comb begin
    cnt_m1 = cnt_q - CNT_W'(1);
    if (cnt_q == '0) begin
      last_idx = '0;
    end else if (int'(cnt_q) > MAX_STOPS) begin
      last_idx = SEL_W'(MAX_STOPS - 1);
    end else begin
      last_idx = cnt_m1[SEL_W-1:0];
    end

    for (int k = 0; k < MAX_STOPS; k++) begin
      past[k] = stop_q[k][STOP_W-1 -: TIME_W] <= age_i;
    end

    seg_idx = last_idx;
    for (int k = MAX_STOPS - 2; k >= 0; k--) begin
      if (SEL_W'(k) < last_idx && !past[k+1]) begin
        seg_idx = SEL_W'(k);
      end
    end

    seg_last = (seg_idx == last_idx);
    nxt_idx  = seg_last ? seg_idx : seg_idx + SEL_W'(1);
  end

  logic [TIME_W-1:0] a_age_q;
  logic [TIME_W-1:0] a_ta_q;
  logic [TIME_W-1:0] a_tb_q;
  rgba_t             a_ca_q;
  rgba_t             a_cb_q;
  logic              a_last_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_age_q  <= age_i;
      a_ta_q   <= stop_q[seg_idx][STOP_W-1 -: TIME_W];
      a_tb_q   <= stop_q[nxt_idx][STOP_W-1 -: TIME_W];
      a_ca_q   <= rgba_t'(stop_q[seg_idx][4*CHAN_W-1:0]);
      a_cb_q   <= rgba_t'(stop_q[nxt_idx][4*CHAN_W-1:0]);
      a_last_q <= seg_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: segment width and offset. The fraction is forced to zero past
  // the last stop, on a too-narrow or descending segment, and when the age
  // sits at or below the lower stop time.
  // ---------------------------------------------------------------------
  logic [TIME_W:0] b_diff;
  logic [TIME_W:0] b_num;
  logic            b_zero;

  always_comb begin
    b_diff = {1'b0, a_tb_q} - {1'b0, a_ta_q};
    b_num  = {1'b0, a_age_q} - {1'b0, a_ta_q};
    b_zero = a_last_q || ($signed(b_diff) < MIN_DIFF) ||
             b_num[TIME_W] || (b_num == '0);
  end

  // Divider pipe registers, index 0 loaded by stage B
  logic [TIME_W-1:0] rem_q  [DIV_STAGES+1];
  logic [TIME_W-1:0] dvs_q  [DIV_STAGES+1];
  logic [T_W-1:0]    quo_q  [DIV_STAGES+1];
  logic              zero_q [DIV_STAGES+1];
  rgba_t             ca_q   [DIV_STAGES+1];
  rgba_t             cb_q   [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rem_q[0]  <= b_zero ? '0 : b_num[TIME_W-1:0];
      dvs_q[0]  <= b_diff[TIME_W-1:0];
      quo_q[0]  <= '0;
      zero_q[0] <= b_zero;
      ca_q[0]   <= a_ca_q;
      cb_q[0]   <= a_cb_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider stages: restoring division of (num << 15) / diff, num < diff,
  // DIV_STEP quotient bits per stage, MSB first.
  // ---------------------------------------------------------------------
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [TIME_W-1:0] rem_n;
    logic [T_W-1:0]    quo_n;
    logic [TIME_W:0]   shl;

    always_comb begin
      rem_n = rem_q[s];
      quo_n = quo_q[s];
      shl   = '0;
      for (int b = 0; b < DIV_STEP; b++) begin
        shl = {rem_n, 1'b0};
        if (shl >= {1'b0, dvs_q[s]}) begin
          shl   = shl - {1'b0, dvs_q[s]};
          quo_n = {quo_n[T_W-2:0], 1'b1};
        end else begin
          quo_n = {quo_n[T_W-2:0], 1'b0};
        end
        rem_n = shl[TIME_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[2+s]) begin
        rem_q[s+1]  <= rem_n;
        dvs_q[s+1]  <= dvs_q[s];
        quo_q[s+1]  <= quo_n;
        zero_q[s+1] <= zero_q[s];
        ca_q[s+1]   <= ca_q[s];
        cb_q[s+1]   <= cb_q[s];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Blend stage: c = (ca * (1.0 - t) + cb * t) >> 15, registered as output
  // ---------------------------------------------------------------------
  logic [T_W-1:0]  t_frac;
  logic [T_W:0]    t_inv;
  rgba_t           ca_m;
  rgba_t           cb_m;
  logic [MIX_W-1:0] mix_r, mix_g, mix_b, mix_a;
  rgba_t           res_q;

  always_comb begin
    t_frac = zero_q[DIV_STAGES] ? '0 : quo_q[DIV_STAGES];
    t_inv  = {1'b1, {T_W{1'b0}}} - {1'b0, t_frac};
    ca_m   = ca_q[DIV_STAGES];
    cb_m   = cb_q[DIV_STAGES];
    mix_r  = MIX_W'(ca_m.red)   * MIX_W'(t_inv) + MIX_W'(cb_m.red)   * MIX_W'(t_frac);
    mix_g  = MIX_W'(ca_m.green) * MIX_W'(t_inv) + MIX_W'(cb_m.green) * MIX_W'(t_frac);
    mix_b  = MIX_W'(ca_m.blue)  * MIX_W'(t_inv) + MIX_W'(cb_m.blue)  * MIX_W'(t_frac);
    mix_a  = MIX_W'(ca_m.alpha) * MIX_W'(t_inv) + MIX_W'(cb_m.alpha) * MIX_W'(t_frac);
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      res_q.red   <= mix_r[T_W +: CHAN_W];
      res_q.green <= mix_g[T_W +: CHAN_W];
      res_q.blue  <= mix_b[T_W +: CHAN_W];
      res_q.alpha <= mix_a[T_W +: CHAN_W];
    end
  end

  assign red_o   = res_q.red;
  assign green_o = res_q.green;
  assign blue_o  = res_q.blue;
  assign alpha_o = res_q.alpha;

endmodule
